[rtl/vrlc_pkg.sv]
package vrlc_pkg;

  localparam int MAX_RECTS = 16;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int IW = $clog2(MAX_RECTS);
  localparam logic signed [17:0] COORD_MAX = 18'sd32767;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CUT   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic signed [15:0]  rect_x;
    logic signed [15:0]  rect_y;
    logic [14:0]         rect_width;
    logic [14:0]         rect_height;
    logic signed [15:0]  request_x;
    logic signed [15:0]  request_y;
    logic [14:0]         request_width;
    logic [14:0]         request_height;
    logic                minimized;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [4:0]          rect_count;
    logic                rect_valid;
    logic signed [15:0]  out_x;
    logic signed [15:0]  out_y;
    logic [14:0]         out_width;
    logic [14:0]         out_height;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0] op;
    logic       rej;
    logic       hit;
    rect_t      rect;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic signed [17:0] x1;
    logic signed [17:0] y1;
    logic signed [17:0] x2;
    logic signed [17:0] y2;
  } ovl_t;

  // intersection of two rectangles on wide coordinates
  function automatic ovl_t rect_overlap(
    input logic signed [17:0] ax, input logic signed [17:0] ay,
    input logic [15:0] aw, input logic [15:0] ah,
    input logic signed [17:0] bx, input logic signed [17:0] by,
    input logic [15:0] bw, input logic [15:0] bh);
    ovl_t o;
    logic signed [17:0] ax2, ay2, bx2, by2;
    ax2 = ax + $signed({2'b00, aw});
    ay2 = ay + $signed({2'b00, ah});
    bx2 = bx + $signed({2'b00, bw});
    by2 = by + $signed({2'b00, bh});
    o.x1 = (ax > bx) ? ax : bx;
    o.y1 = (ay > by) ? ay : by;
    o.x2 = (ax2 < bx2) ? ax2 : bx2;
    o.y2 = (ay2 < by2) ? ay2 : by2;
    o.hit = (aw != 16'd0) && (ah != 16'd0) && (bw != 16'd0) && (bh != 16'd0) &&
            (o.x1 < o.x2) && (o.y1 < o.y2) && (o.x1 <= COORD_MAX) && (o.y1 <= COORD_MAX);
    return o;
  endfunction

endpackage

[rtl/vrlc_front.sv]
module vrlc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  vrlc_pkg::in_item_t in_data,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output vrlc_pkg::cmd_t     cmd
);
  import vrlc_pkg::*;

  logic [7:0]         title_r;
  logic [7:0]         title_nxt;
  logic signed [17:0] cx, cy;
  logic [15:0]        cw, ch;
  ovl_t               ov;

  // title height register
  assign title_nxt = cfg_valid ? cfg_data : title_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      title_r <= 8'd16;
    end else begin
      title_r <= title_nxt;
    end
  end

  // client area and its cut with the request
  always_comb begin
    cx = 18'(in_data.rect_x) + 18'sd1;
    cy = 18'(in_data.rect_y) + $signed({10'd0, title_r});
    cw = {1'b0, in_data.rect_width} - 16'd2;
    ch = {1'b0, in_data.rect_height} - {8'd0, title_r} - 16'd1;
    ov = rect_overlap(cx, cy, cw, ch,
                      18'(in_data.request_x), 18'(in_data.request_y),
                      {1'b0, in_data.request_width}, {1'b0, in_data.request_height});
  end

  // classify
  always_comb begin
    cmd.op  = in_data.opcode;
    cmd.rej = in_data.minimized || (in_data.rect_width <= 15'd2) ||
              ({1'b0, in_data.rect_height} <= ({8'd0, title_r} + 16'd1));
    cmd.hit = ov.hit;
    if (in_data.opcode == OP_START) begin
      cmd.rect.x = ov.x1[15:0];
      cmd.rect.y = ov.y1[15:0];
      cmd.rect.w = 15'(ov.x2 - ov.x1);
      cmd.rect.h = 15'(ov.y2 - ov.y1);
    end else begin
      cmd.rect.x = in_data.rect_x;
      cmd.rect.y = in_data.rect_y;
      cmd.rect.w = in_data.rect_width;
      cmd.rect.h = in_data.rect_height;
    end
  end

endmodule

[rtl/vrlc_cmdq.sv]
module vrlc_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  vrlc_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output vrlc_pkg::cmd_t rd_data,
  output logic           empty
);
  import vrlc_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  // pointers and fill level
  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

[rtl/vrlc_back.sv]
module vrlc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vrlc_pkg::cmd_t      cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output vrlc_pkg::out_item_t out_data,
  output logic                empty,
  input  logic                pop
);
  import vrlc_pkg::*;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_CUT_RD = 3'd1;
  localparam logic [2:0] B_CUT_PC = 3'd2;
  localparam logic [2:0] B_RD     = 3'd3;
  localparam logic [2:0] B_RES    = 3'd4;

  rect_t              bank_r [2][MAX_RECTS];
  logic [2:0]         state_r, state_nxt;
  logic               cur_r, cur_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, ncnt_r, ncnt_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [1:0]         pc_r, pc_nxt;
  logic               drop_r, drop_nxt;
  logic [1:0]         stat_r, stat_nxt;
  rect_t              cover_r, cover_nxt, s_r, s_nxt;
  logic signed [17:0] ix1_r, iy1_r, ix2_r, iy2_r;
  logic               ovalid_r, ovalid_nxt;
  out_item_t          o_r, o_nxt;
  rect_t              cur_rect;
  ovl_t               ov;
  logic               out_free, is_last;
  logic               push_en, push_ok, push_wr, adv;
  logic signed [17:0] px, py, pw, ph, sx, sy, sx2, sy2;
  logic               start_wr;
  logic [CW-1:0]      ncnt_v;
  logic               drop_v;

  assign out_free = !ovalid_r || pop;
  assign empty    = !ovalid_r;
  assign out_data = o_r;
  assign cur_rect = bank_r[cur_r][idx_r];
  assign is_last  = ({1'b0, idx_r} + CW'(1)) == cnt_r;

  // overlap of the current entry with the cover
  assign ov = rect_overlap(18'(cur_rect.x), 18'(cur_rect.y),
                           {1'b0, cur_rect.w}, {1'b0, cur_rect.h},
                           18'(cover_r.x), 18'(cover_r.y),
                           {1'b0, cover_r.w}, {1'b0, cover_r.h});

  // entry to push: an untouched entry whole, or remainder pieces: top, bottom, left, right
  always_comb begin
    sx  = 18'(s_r.x);
    sy  = 18'(s_r.y);
    sx2 = sx + $signed({3'b000, s_r.w});
    sy2 = sy + $signed({3'b000, s_r.h});
    push_en = 1'b0;
    px = sx; py = sy; pw = $signed({3'b000, s_r.w}); ph = $signed({3'b000, s_r.h});
    if (state_r == B_CUT_RD) begin
      push_en = !ov.hit;
      px = 18'(cur_rect.x);
      py = 18'(cur_rect.y);
      pw = $signed({3'b000, cur_rect.w});
      ph = $signed({3'b000, cur_rect.h});
    end else if (state_r == B_CUT_PC) begin
      push_en = 1'b1;
      unique case (pc_r)
        2'd0: begin
          ph = iy1_r - sy;
        end
        2'd1: begin
          py = iy2_r;
          ph = sy2 - iy2_r;
        end
        2'd2: begin
          py = iy1_r;
          pw = ix1_r - sx;
          ph = iy2_r - iy1_r;
        end
        default: begin
          px = ix2_r;
          py = iy1_r;
          pw = sx2 - ix2_r;
          ph = iy2_r - iy1_r;
        end
      endcase
    end
    push_ok = push_en && (pw != 18'sd0) && (ph != 18'sd0) &&
              (px <= COORD_MAX) && (py <= COORD_MAX);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; cur_nxt = cur_r; cnt_nxt = cnt_r; ncnt_nxt = ncnt_r;
    idx_nxt = idx_r; pc_nxt = pc_r; drop_nxt = drop_r; stat_nxt = stat_r;
    cover_nxt = cover_r; s_nxt = s_r;
    ovalid_nxt = ovalid_r && !pop; o_nxt = o_r;
    cmd_pop = 1'b0; start_wr = 1'b0; adv = 1'b0;
    push_wr = push_ok && (ncnt_r < CW'(MAX_RECTS));
    ncnt_v  = push_wr ? ncnt_r + CW'(1) : ncnt_r;
    drop_v  = drop_r || (push_ok && !push_wr);
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          stat_nxt  = ST_OK;
          state_nxt = B_RES;
          idx_nxt   = '0;
          unique case (cmd.op)
            OP_START: begin
              if (cmd.rej) begin
                stat_nxt = ST_REJ;
              end else begin
                start_wr = cmd.hit;
                cnt_nxt  = cmd.hit ? CW'(1) : CW'(0);
              end
            end
            OP_CUT: begin
              cover_nxt = cmd.rect;
              ncnt_nxt  = '0;
              drop_nxt  = 1'b0;
              if (cnt_r != '0) begin
                state_nxt = B_CUT_RD;
              end
            end
            OP_READ: begin
              if (cnt_r != '0) begin
                state_nxt = B_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_CUT_RD: begin
        ncnt_nxt = ncnt_v;
        drop_nxt = drop_v;
        if (ov.hit) begin
          s_nxt     = cur_rect;
          pc_nxt    = 2'd0;
          state_nxt = B_CUT_PC;
        end else begin
          adv = 1'b1;
        end
      end
      B_CUT_PC: begin
        ncnt_nxt = ncnt_v;
        drop_nxt = drop_v;
        pc_nxt   = pc_r + 2'd1;
        adv      = (pc_r == 2'd3);
      end
      B_RD: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          o_nxt = '{status: ST_OK, rect_count: 5'(cnt_r), rect_valid: 1'b1,
                    out_x: cur_rect.x, out_y: cur_rect.y, out_width: cur_rect.w,
                    out_height: cur_rect.h, last: is_last};
          if (is_last) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      B_RES: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          o_nxt = '{status: stat_r, rect_count: 5'(cnt_r), rect_valid: 1'b0,
                    out_x: 16'sd0, out_y: 16'sd0, out_width: 15'd0,
                    out_height: 15'd0, last: 1'b1};
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    // step to the next source entry, or swap banks at the end
    if (adv) begin
      if (is_last) begin
        cnt_nxt   = ncnt_v;
        cur_nxt   = ~cur_r;
        stat_nxt  = drop_v ? ST_DROP : ST_OK;
        state_nxt = B_RES;
      end else begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = B_CUT_RD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      cur_r    <= 1'b0;
      cnt_r    <= '0;
      ncnt_r   <= '0;
      idx_r    <= '0;
      pc_r     <= 2'd0;
      drop_r   <= 1'b0;
      stat_r   <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      cnt_r    <= cnt_nxt;
      ncnt_r   <= ncnt_nxt;
      idx_r    <= idx_nxt;
      pc_r     <= pc_nxt;
      drop_r   <= drop_nxt;
      stat_r   <= stat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers and list banks
  always_ff @(posedge clk) begin
    cover_r <= cover_nxt;
    s_r     <= s_nxt;
    o_r     <= o_nxt;
    if (state_r == B_CUT_RD && ov.hit) begin
      ix1_r <= ov.x1;
      iy1_r <= ov.y1;
      ix2_r <= ov.x2;
      iy2_r <= ov.y2;
    end
    if (start_wr) begin
      bank_r[cur_r][0] <= cmd.rect;
    end
    if (push_wr) begin
      bank_r[~cur_r][ncnt_r[IW-1:0]] <= '{x: px[15:0], y: py[15:0],
                                          w: pw[14:0], h: ph[14:0]};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECTS)) else $error("list count beyond capacity");
  a_ncnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r <= CW'(MAX_RECTS)) else $error("new list count beyond capacity");
  a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD) |-> ({1'b0, idx_r} < cnt_r)) else $error("read index past list end");
  a_cut_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CUT_RD) |-> ({1'b0, idx_r} < cnt_r)) else $error("cut index past list end");
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r != $past(cur_r)) |-> (state_r == B_RES)) else $error("bank swap outside cut end");

endmodule

[rtl/visible_rect_list_clipper.sv]
// visible rectangle list clipper
// input channel: push/full with in_data; an item is taken when push is high
// and full is low. opcode start loads the list from the window client area
// cut with the request, cut subtracts a cover rectangle, read out emits the
// list. results: empty/pop with out_data; the oldest result is shown while
// empty is low and is taken when pop is high.
// configuration: cfg_valid/cfg_ready/cfg_data writes the title height; the
// port is always ready. the user must see that it is written only while the
// block is idle; the block itself does not enforce this. a two-deep command
// queue lets the front take new items while the back is busy or its single
// output register waits on pop. a read out gives one result per cycle while
// pop keeps the output register free. a cut walks the list once, copying
// each untouched entry and splitting each entry that overlaps the cover
// into top, bottom, left and right pieces. reset clears the list count,
// queue and output valid and sets the title height to 16; list storage is
// not cleared. when pop stays low, the back holds and the queue fills, then
// full rises.
module visible_rect_list_clipper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  vrlc_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output vrlc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import vrlc_pkg::*;

  cmd_t fcmd, qcmd;
  logic q_empty, q_pop;

  assign cfg_ready = 1'b1;

  vrlc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (fcmd)
  );

  vrlc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (push),
    .wr_data (fcmd),
    .full    (full),
    .rd      (q_pop),
    .rd_data (qcmd),
    .empty   (q_empty)
  );

  vrlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (qcmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
